// ===== sv/wfwes_pkg.sv =====
// Package for the wire-format window-end scanner.
// Holds the shared codes, widths and defaults; it depends on nothing else.
package wfwes_pkg;

  localparam int WINDOW_MAX_DEF = 16;
  localparam int VERDICT_W      = 2;
  localparam int ACC_W          = 32;
  localparam int DEPTH_W        = 8;

  typedef enum logic [1:0] {
    V_UNDECIDED = 2'd0,
    V_ENDS      = 2'd1,
    V_NOT       = 2'd2
  } verdict_e;

  typedef enum logic [3:0] {
    PH_TAG   = 4'b0001,
    PH_VALUE = 4'b0010,
    PH_SIZE  = 4'b0100,
    PH_SKIP  = 4'b1000
  } phase_e;

  typedef enum logic [2:0] {
    WT_VARINT  = 3'd0,
    WT_FIXED64 = 3'd1,
    WT_LENGTH  = 3'd2,
    WT_SGROUP  = 3'd3,
    WT_EGROUP  = 3'd4,
    WT_FIXED32 = 3'd5
  } wire_type_e;

endpackage

// ===== sv/wire_format_window_end_scanner.sv =====
// An accepted item's result is registered, in the skid entry while the output stalls.
// Throughput: one item per cycle while in_stall_o is low; one scan-state pass per byte.
// A one-entry skid stage behind the result register holds one result while another waits.
// Reset is asynchronous and active low; it clears the scan state to reading a tag,
// no open window and an undecided verdict.
// Depends on wfwes_pkg.
module wire_format_window_end_scanner #(
  parameter int WINDOW_MAX = wfwes_pkg::WINDOW_MAX_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [7:0]                       data_byte_i,
  input  logic                             first_i,
  input  logic [4:0]                       window_bytes_i,
  input  logic [6:0]                       start_depth_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [wfwes_pkg::VERDICT_W-1:0]  verdict_o,
  output logic                             window_end_o
);
  import wfwes_pkg::*;

  localparam int BW = $clog2(WINDOW_MAX + 1);
  localparam int CW = $clog2(((WINDOW_MAX > 8) ? WINDOW_MAX : 8) + 1);

  phase_e             phase_q, phase_d;
  logic [ACC_W-1:0]   acc_q, acc_d;
  logic [3:0]         vb_q, vb_d;
  logic [CW-1:0]      skip_q, skip_d;
  logic [BW-1:0]      left_q, left_d;
  logic [DEPTH_W-1:0] depth_q, depth_d;
  verdict_e           verd_q, verd_d;

  logic               accept, out_fire, res_end;
  verdict_e           ov_verd_q, sk_verd_q;
  logic               ov_valid_q, ov_end_q, sk_valid_q, sk_end_q;

  assign in_stall_o = sk_valid_q;
  assign accept     = in_valid_i & ~sk_valid_q;
  assign out_fire   = ov_valid_q & ~out_stall_i;

  always_comb begin
    logic [2:0]       k;
    logic [5:0]       sh;
    logic [ACC_W-1:0] acc_n;
    logic [BW-1:0]    rem;

    phase_d = phase_q;
    acc_d   = acc_q;
    vb_d    = vb_q;
    skip_d  = skip_q;
    left_d  = left_q;
    depth_d = depth_q;
    verd_d  = verd_q;
    res_end = 1'b0;

    if (first_i) begin
      phase_d = PH_TAG;
      acc_d   = '0;
      vb_d    = '0;
      skip_d  = '0;
      if (window_bytes_i == 5'd0) begin
        left_d = BW'(1);
      end else if (32'(window_bytes_i) > WINDOW_MAX) begin
        left_d = BW'(WINDOW_MAX);
      end else begin
        left_d = BW'(window_bytes_i);
      end
      depth_d = {1'b0, start_depth_i};
      verd_d  = V_UNDECIDED;
    end

    k     = vb_d[2:0];
    sh    = ({3'b0, k} << 3) - {3'b0, k};
    acc_n = acc_d | (ACC_W'({25'b0, data_byte_i[6:0]}) << sh);
    rem   = left_d - BW'(1);

    if (left_d != '0) begin
      left_d = rem;
      if (verd_d == V_UNDECIDED) begin
        unique case (phase_d)
          PH_TAG: begin
            if (k > 3'd4) begin
              verd_d = V_NOT;
            end else begin
              acc_d = acc_n;
              vb_d  = {1'b0, k} + 4'd1;
              if (data_byte_i[7]) begin
                if (vb_d >= 4'd5) verd_d = V_NOT;
              end else begin
                acc_d = '0;
                vb_d  = '0;
                if (acc_n == '0) begin
                  verd_d = V_ENDS;
                end else begin
                  case (acc_n[2:0])
                    WT_VARINT:  phase_d = PH_VALUE;
                    WT_FIXED64: begin
                      skip_d  = CW'(8);
                      phase_d = PH_SKIP;
                    end
                    WT_LENGTH:  phase_d = PH_SIZE;
                    WT_SGROUP: begin
                      if (depth_d != '1) depth_d = depth_d + DEPTH_W'(1);
                    end
                    WT_EGROUP: begin
                      if (depth_d == '0) verd_d = V_ENDS;
                      else depth_d = depth_d - DEPTH_W'(1);
                    end
                    WT_FIXED32: begin
                      skip_d  = CW'(4);
                      phase_d = PH_SKIP;
                    end
                    default:    verd_d = V_NOT;
                  endcase
                end
              end
            end
          end
          PH_VALUE: begin
            vb_d = vb_d + 4'd1;
            if (data_byte_i[7]) begin
              if (vb_d >= 4'd10) verd_d = V_NOT;
            end else begin
              vb_d    = '0;
              phase_d = PH_TAG;
            end
          end
          PH_SIZE: begin
            if (k > 3'd4 || (k == 3'd4 && data_byte_i >= 8'd8)) begin
              verd_d = V_NOT;
            end else begin
              acc_d = acc_n;
              vb_d  = {1'b0, k} + 4'd1;
              if (!data_byte_i[7]) begin
                acc_d = '0;
                vb_d  = '0;
                if (acc_n > ACC_W'(rem)) begin
                  verd_d = V_NOT;
                end else if (acc_n == '0) begin
                  phase_d = PH_TAG;
                end else begin
                  skip_d  = acc_n[CW-1:0];
                  phase_d = PH_SKIP;
                end
              end
            end
          end
          PH_SKIP: begin
            if (skip_d != '0) skip_d = skip_d - CW'(1);
            if (skip_d == '0) phase_d = PH_TAG;
          end
          default: verd_d = V_NOT;
        endcase
      end
      if (rem == '0) begin
        res_end = 1'b1;
        if (verd_d == V_UNDECIDED) verd_d = V_NOT;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_TAG;
      acc_q   <= '0;
      vb_q    <= '0;
      skip_q  <= '0;
      left_q  <= '0;
      depth_q <= '0;
      verd_q  <= V_UNDECIDED;
    end else if (accept) begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
      vb_q    <= vb_d;
      skip_q  <= skip_d;
      left_q  <= left_d;
      depth_q <= depth_d;
      verd_q  <= verd_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_valid_q <= 1'b0;
      sk_valid_q <= 1'b0;
    end else if (sk_valid_q) begin
      if (out_fire) begin
        sk_valid_q <= 1'b0;
      end
    end else if (accept) begin
      if (!ov_valid_q || out_fire) begin
        ov_valid_q <= 1'b1;
      end else begin
        sk_valid_q <= 1'b1;
      end
    end else if (out_fire) begin
      ov_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sk_valid_q) begin
      if (out_fire) begin
        ov_verd_q <= sk_verd_q;
        ov_end_q  <= sk_end_q;
      end
    end else if (accept) begin
      if (!ov_valid_q || out_fire) begin
        ov_verd_q <= verd_d;
        ov_end_q  <= res_end;
      end else begin
        sk_verd_q <= verd_d;
        sk_end_q  <= res_end;
      end
    end
  end

  assign out_valid_o  = ov_valid_q;
  assign verdict_o    = ov_verd_q;
  assign window_end_o = ov_end_q;

endmodule

// ===== sv/wfwes_checker.sv =====
// Port-level checker for the wire-format window-end scanner, with its bind.
// Depends on wfwes_pkg and on the ports of wire_format_window_end_scanner.
module wfwes_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_stall_o,
  input logic                             out_valid_o,
  input logic                             out_stall_i,
  input logic [wfwes_pkg::VERDICT_W-1:0]  verdict_o,
  input logic                             window_end_o
);
  import wfwes_pkg::*;

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(verdict_o) && $stable(window_end_o))
    else $error("stalled result changed");

  // The skid entry is only filled behind a full result register.
  a_stall_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no result pending");

  // The skid entry drains as soon as the output side takes a result.
  a_skid_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o && !out_stall_i |=> !in_stall_o)
    else $error("skid entry did not drain");

  // The last byte of a window always carries a decision.
  a_end_decided: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && window_end_o |-> verdict_o != V_UNDECIDED)
    else $error("window ended undecided");

endmodule

bind wire_format_window_end_scanner wfwes_checker u_wfwes_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .verdict_o    (verdict_o),
  .window_end_o (window_end_o)
);
